/* rtl/core/cwt_pkg.sv */
// ----------------------------------------------------------------------------
// cwt_pkg: shared types and constants of the card whitelist table
// sizes of the table, command codes and result status codes
// ----------------------------------------------------------------------------
`default_nettype none

package cwt_pkg;

  localparam int TABLE_ENTRIES = 128;

  // slot index and fill counter widths
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // port field widths
  localparam int CMD_W    = 3;
  localparam int ID_W     = 32;
  localparam int SLOT_W   = 7;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 8;
  localparam int FILL_W   = 8;

  // one table word holds the identifier above its use count
  localparam int WORD_W = ID_W + COUNT_W;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_PRESENT = 3'd0;
  localparam cmd_t CMD_ADD     = 3'd1;
  localparam cmd_t CMD_CLEAR   = 3'd2;
  localparam cmd_t CMD_READ    = 3'd3;
  localparam cmd_t CMD_TOTAL   = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NOT_FOUND = 3'd1;
  localparam status_t ST_ALREADY   = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

endpackage

`default_nettype wire

/* rtl/core/cwt_ram.sv */
// ----------------------------------------------------------------------------
// cwt_ram: generic single-write, single-read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module cwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/card_whitelist_table.sv */
// ----------------------------------------------------------------------------
// card_whitelist_table: table of authorised card identifiers with use counts
// present, add, clear, read entry and total commands, one result per command
// ----------------------------------------------------------------------------
// Usage:
//   in_*  channel carries one command beat (command, card_id, slot_select).
//   out_* channel returns exactly one result beat per command with status,
//   slot, stored_id, use_count and fill_level.
//   The block takes one command at a time; in_ready is high while idle, also
//   when an earlier result still sits in the output register.
//   Present and add scan the stored entries in slot order through one table
//   memory, one slot per cycle while the output register is free, with the
//   compare on the registered read word. A match stops the scan early.
//   Read entry passes through a read-wait step; clear, total and unused
//   codes go straight to the final step.
//   The table memory has one write and one read port; the compare of the
//   returned word is the loop that sets the scan rate.
//   Reset empties the table (fill level zero); memory contents need no reset
//   since only slots below the fill level are ever read.
//   While out_valid is high and out_ready low the result holds and the
//   sequencer waits, during a scan at each of its steps.
// ----------------------------------------------------------------------------
`default_nettype none

module card_whitelist_table
  import cwt_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [CMD_W-1:0]    in_command,
  input  wire logic [ID_W-1:0]     in_card_id,
  input  wire logic [SLOT_W-1:0]   in_slot_select,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [ID_W-1:0]          out_stored_id,
  output logic [COUNT_W-1:0]       out_use_count,
  output logic [FILL_W-1:0]        out_fill_level
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;
  localparam logic [1:0] S_DONE   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [ID_W-1:0]     key_r, key_nxt;
  logic [CNT_W-1:0]    scan_cnt_r, scan_cnt_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                rd_ok_r, rd_ok_nxt;
  logic [IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]    fill_r, fill_nxt;

  logic                out_valid_r, out_valid_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [COUNT_W-1:0]  out_count_r, out_count_nxt;
  logic [FILL_W-1:0]   out_fill_r, out_fill_nxt;

  // table memory
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [WORD_W-1:0]   ram_wdata;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_raddr;
  logic [WORD_W-1:0]   ram_rdata;

  logic [ID_W-1:0]     rd_id;
  logic [COUNT_W-1:0]  rd_count;
  logic [COUNT_W-1:0]  inc_count;
  logic                out_free;
  logic                accept;
  logic                hit;
  logic                scan_end;
  logic                sel_ok;

  cwt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_id     = ram_rdata[WORD_W-1:COUNT_W];
  assign rd_count  = ram_rdata[COUNT_W-1:0];
  assign inc_count = (rd_count == COUNT_MAX) ? rd_count : rd_count + 1'b1;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign hit      = cmp_vld_r && (rd_id == key_r);
  assign scan_end = !(scan_cnt_r < fill_r);
  assign sel_ok   = (32'(in_slot_select) < 32'(fill_r))
                 && (32'(in_slot_select) < TABLE_ENTRIES);

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    scan_cnt_nxt  = scan_cnt_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    rd_ok_nxt     = rd_ok_r;
    rd_idx_nxt    = rd_idx_r;
    fill_nxt      = fill_r;

    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_id_nxt     = out_id_r;
    out_count_nxt  = out_count_r;
    out_fill_nxt   = out_fill_r;

    ram_we    = 1'b0;
    ram_waddr = cmp_idx_r;
    ram_wdata = {rd_id, inc_count};
    ram_re    = 1'b0;
    ram_raddr = scan_cnt_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt      = in_command;
          key_nxt      = in_card_id;
          scan_cnt_nxt = '0;
          cmp_vld_nxt  = 1'b0;
          case (in_command)
            CMD_PRESENT, CMD_ADD: begin
              state_nxt = S_SCAN;
            end
            CMD_READ: begin
              rd_ok_nxt  = sel_ok;
              rd_idx_nxt = IDX_W'(in_slot_select);
              ram_re     = sel_ok;
              ram_raddr  = IDX_W'(in_slot_select);
              state_nxt  = S_RDWAIT;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        // whole step waits for a free output register
        if (out_free) begin
          if (hit) begin
            state_nxt      = S_IDLE;
            out_valid_nxt  = 1'b1;
            out_slot_nxt   = SLOT_W'(cmp_idx_r);
            out_id_nxt     = rd_id;
            out_fill_nxt   = FILL_W'(fill_r);
            if (cmd_r == CMD_PRESENT) begin
              ram_we         = 1'b1;
              out_status_nxt = ST_OK;
              out_count_nxt  = inc_count;
            end else begin
              out_status_nxt = ST_ALREADY;
              out_count_nxt  = rd_count;
            end
          end else if (scan_end) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = 1'b1;
            out_slot_nxt  = '0;
            out_id_nxt    = '0;
            out_count_nxt = '0;
            out_fill_nxt  = FILL_W'(fill_r);
            if (cmd_r == CMD_PRESENT) begin
              out_status_nxt = ST_NOT_FOUND;
            end else if (fill_r == CNT_W'(TABLE_ENTRIES)) begin
              out_status_nxt = ST_FULL;
            end else begin
              // append at the end of the table with count zero
              ram_we         = 1'b1;
              ram_waddr      = fill_r[IDX_W-1:0];
              ram_wdata      = {key_r, {COUNT_W{1'b0}}};
              fill_nxt       = fill_r + 1'b1;
              out_status_nxt = ST_OK;
              out_slot_nxt   = SLOT_W'(fill_r);
              out_id_nxt     = key_r;
              out_fill_nxt   = FILL_W'(fill_r + 1'b1);
            end
          end else begin
            // read next slot, compare the registered word at the following scan step
            ram_re       = 1'b1;
            cmp_vld_nxt  = 1'b1;
            cmp_idx_nxt  = scan_cnt_r[IDX_W-1:0];
            scan_cnt_nxt = scan_cnt_r + 1'b1;
          end
        end
      end

      S_RDWAIT: begin
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_fill_nxt  = FILL_W'(fill_r);
          if (rd_ok_r) begin
            out_status_nxt = ST_OK;
            out_slot_nxt   = SLOT_W'(rd_idx_r);
            out_id_nxt     = rd_id;
            out_count_nxt  = rd_count;
          end else begin
            out_status_nxt = ST_EMPTY;
            out_slot_nxt   = '0;
            out_id_nxt     = '0;
            out_count_nxt  = '0;
          end
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_slot_nxt   = '0;
          out_id_nxt     = '0;
          out_count_nxt  = '0;
          if (cmd_r == CMD_CLEAR) begin
            fill_nxt     = '0;
            out_fill_nxt = '0;
          end else begin
            out_fill_nxt = FILL_W'(fill_r);
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    cmp_idx_r    <= cmp_idx_nxt;
    rd_ok_r      <= rd_ok_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_id_r     <= out_id_nxt;
    out_count_r  <= out_count_nxt;
    out_fill_r   <= out_fill_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_stored_id  = out_id_r;
  assign out_use_count  = out_count_r;
  assign out_fill_level = out_fill_r;

endmodule

`default_nettype wire

/* tb/sv/card_whitelist_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_whitelist_table_tb: self-checking bench for the card whitelist table
// drives command beats with random gaps, stalls the result side at random,
// predicts every result from a shadow copy of the table and compares fields
// ----------------------------------------------------------------------------

module card_whitelist_table_tb;
  import cwt_pkg::*;

  localparam int   CYCLE_LIMIT   = 1_000_000;
  localparam int   DRAIN_CYCLES  = TABLE_ENTRIES + 12;
  localparam int   REPORT_MAX    = 50;
  localparam cmd_t CMD_SPARE_LO  = 3'd5;
  localparam cmd_t CMD_SPARE_HI  = 3'd7;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot;
    logic [ID_W-1:0]      stored_id;
    logic [COUNT_W-1:0]   use_count;
    logic [FILL_W-1:0]    fill_level;
  } card_result_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    in_command = '0;
  logic [ID_W-1:0]     in_card_id = '0;
  logic [SLOT_W-1:0]   in_slot_select = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [SLOT_W-1:0]   out_slot;
  logic [ID_W-1:0]     out_stored_id;
  logic [COUNT_W-1:0]  out_use_count;
  logic [FILL_W-1:0]   out_fill_level;

  // shadow of the table contents
  logic [ID_W-1:0]    ids_held  [TABLE_ENTRIES];
  logic [COUNT_W-1:0] uses_held [TABLE_ENTRIES];
  int unsigned        fill_held = 0;

  card_result_t due_results[$];
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;
  int unsigned  stall_left = 0;
  bit           steady_flow = 1'b0;

  card_whitelist_table u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_card_id     (in_card_id),
    .in_slot_select (in_slot_select),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_slot       (out_slot),
    .out_stored_id  (out_stored_id),
    .out_use_count  (out_use_count),
    .out_fill_level (out_fill_level)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // linear search of the shadow table, same order as the hardware scan
  function automatic int find_held(logic [ID_W-1:0] id);
    for (int i = 0; i < fill_held; i++) begin
      if (ids_held[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic logic [ID_W-1:0] pick_held_id();
    return ids_held[$urandom_range(0, fill_held - 1)];
  endfunction

  function automatic card_result_t table_command(cmd_t cmd, logic [ID_W-1:0] id,
                                                 logic [SLOT_W-1:0] sel);
    card_result_t res;
    int           at;
    res = '0;
    res.status = ST_OK;
    case (cmd)
      CMD_PRESENT: begin
        at = find_held(id);
        if (at >= 0) begin
          if (uses_held[at] != COUNT_MAX) uses_held[at] = uses_held[at] + 1'b1;
          res.slot      = SLOT_W'(at);
          res.stored_id = ids_held[at];
          res.use_count = uses_held[at];
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      CMD_ADD: begin
        at = find_held(id);
        if (at >= 0) begin
          res.status    = ST_ALREADY;
          res.slot      = SLOT_W'(at);
          res.stored_id = ids_held[at];
          res.use_count = uses_held[at];
        end else if (fill_held >= TABLE_ENTRIES) begin
          res.status = ST_FULL;
        end else begin
          ids_held[fill_held]  = id;
          uses_held[fill_held] = '0;
          res.slot      = SLOT_W'(fill_held);
          res.stored_id = id;
          fill_held++;
        end
      end
      CMD_CLEAR: begin
        fill_held = 0;
      end
      CMD_READ: begin
        if (sel < fill_held) begin
          res.slot      = sel;
          res.stored_id = ids_held[sel];
          res.use_count = uses_held[sel];
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: ;
    endcase
    res.fill_level = FILL_W'(fill_held);
    return res;
  endfunction

  // one command beat; valid stays up across back-to-back beats
  task automatic send_item(cmd_t cmd, logic [ID_W-1:0] id, logic [SLOT_W-1:0] sel);
    int unsigned gap;
    gap = steady_flow ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_command     = cmd;
    in_card_id     = id;
    in_slot_select = sel;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    due_results.push_back(table_command(cmd, id, sel));
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    if (steady_flow) begin
      stall_left = 0;
      out_ready  = 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready = 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = pick_gap();
      out_ready  = 1'b0;
    end else begin
      out_ready = 1'b1;
    end
  end

  task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    card_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result beat with none pending, expected nothing, actual %0h",
                   $time, out_stored_id);
      end else begin
        want = due_results.pop_front();
        check_field("status",     ID_W'(want.status),     ID_W'(out_status));
        check_field("slot",       ID_W'(want.slot),       ID_W'(out_slot));
        check_field("stored_id",  want.stored_id,         out_stored_id);
        check_field("use_count",  ID_W'(want.use_count),  ID_W'(out_use_count));
        check_field("fill_level", ID_W'(want.fill_level), ID_W'(out_fill_level));
      end
    end
  end

  task automatic test_directed_cases();
    send_item(CMD_TOTAL,    '0, '0);
    send_item(CMD_READ,     '0, '0);
    send_item(CMD_PRESENT,  32'hDEAD_BEEF, '0);
    send_item(CMD_ADD,      32'h0000_0000, 7'h7F);
    send_item(CMD_ADD,      32'hFFFF_FFFF, '0);
    send_item(CMD_ADD,      32'h0000_0000, '0);
    send_item(CMD_PRESENT,  32'hFFFF_FFFF, '0);
    send_item(CMD_PRESENT,  32'hFFFF_FFFF, 7'h7F);
    send_item(CMD_PRESENT,  32'h7FFF_FFFF, '0);
    send_item(CMD_READ,     '1, 7'd1);
    send_item(CMD_READ,     '0, 7'd2);
    send_item(CMD_READ,     '0, 7'h7F);
    send_item(CMD_TOTAL,    '1, '1);
    send_item(CMD_SPARE_LO, 32'h0000_0000, '0);
    send_item(cmd_t'(CMD_SPARE_LO + 1'b1), 32'hFFFF_FFFF, '1);
    send_item(CMD_SPARE_HI, 32'hFFFF_FFFF, '1);
    send_item(CMD_CLEAR,    '1, '1);
    send_item(CMD_TOTAL,    '0, '0);
    send_item(CMD_READ,     '0, '0);
    send_item(CMD_PRESENT,  32'hFFFF_FFFF, '0);
    send_item(CMD_ADD,      32'hA5A5_5A5A, '0);
    send_item(CMD_READ,     '0, '0);
    send_item(CMD_PRESENT,  32'hA5A5_5A5A, '0);
  endtask

  task automatic test_fill_to_capacity();
    send_item(CMD_CLEAR, $urandom(), 7'($urandom()));
    while (fill_held < TABLE_ENTRIES) begin
      if (fill_held > 0 && $urandom_range(0, 9) == 0)
        send_item(CMD_ADD, pick_held_id(), 7'($urandom()));
      else
        send_item(CMD_ADD, $urandom(), 7'($urandom()));
    end
    send_item(CMD_ADD,     $urandom(), '0);
    send_item(CMD_ADD,     ids_held[TABLE_ENTRIES-1], '0);
    send_item(CMD_ADD,     ids_held[0], '0);
    send_item(CMD_PRESENT, ids_held[TABLE_ENTRIES-1], '0);
    send_item(CMD_PRESENT, ids_held[0], '0);
    send_item(CMD_PRESENT, $urandom(), '0);
    send_item(CMD_READ,    '0, 7'(TABLE_ENTRIES - 1));
    send_item(CMD_READ,    '0, '0);
    send_item(CMD_TOTAL,   '0, '0);
    repeat (10) send_item(CMD_READ, $urandom(), 7'($urandom()));
  endtask

  task automatic test_count_saturation();
    logic [ID_W-1:0] hot_id;
    hot_id = $urandom();
    send_item(CMD_CLEAR, '0, '0);
    send_item(CMD_ADD, hot_id, '0);
    send_item(CMD_ADD, hot_id ^ 32'h8000_0001, '0);
    // walk the count past its ceiling
    repeat (258) send_item(CMD_PRESENT, hot_id, 7'($urandom()));
    send_item(CMD_ADD,  hot_id, '0);
    send_item(CMD_READ, '0, '0);
    send_item(CMD_READ, '0, 7'd1);
  endtask

  // mostly hits on stored ids, with near misses and random noise mixed in
  task automatic test_random_traffic(int unsigned beats);
    int unsigned     r;
    cmd_t            cmd;
    logic [ID_W-1:0] id;
    logic [SLOT_W-1:0] sel;
    repeat (beats) begin
      r   = $urandom_range(0, 99);
      id  = $urandom();
      sel = 7'($urandom());
      if (r < 40)      cmd = CMD_PRESENT;
      else if (r < 72) cmd = CMD_ADD;
      else if (r < 73) cmd = CMD_CLEAR;
      else if (r < 88) cmd = CMD_READ;
      else if (r < 94) cmd = CMD_TOTAL;
      else             cmd = cmd_t'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
      r = $urandom_range(0, 99);
      if (fill_held > 0) begin
        if (cmd == CMD_PRESENT && r < 75)   id = pick_held_id();
        else if (cmd == CMD_PRESENT && r < 88)
          id = pick_held_id() ^ (32'd1 << $urandom_range(0, ID_W - 1));
        else if (cmd == CMD_ADD && r < 35)  id = pick_held_id();
        else if (cmd == CMD_READ && r < 80) sel = 7'($urandom_range(0, fill_held - 1));
      end
      send_item(cmd, id, sel);
    end
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    test_random_traffic(80);
    steady_flow = 1'b0;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_fill_to_capacity();
    test_count_saturation();
    test_random_traffic(540);
    test_back_to_back();

    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
